@@ hw/rtl/sc2hid_pkg.sv @@
package sc2hid_pkg;

  typedef struct packed {
    logic [7:0] scan_code;
    logic       extended;
    logic [1:0] key_action;
  } key_event_t;

  typedef struct packed {
    logic [7:0] hid_usage;
    logic       pressed;
    logic [3:0] modifier_mask;
  } hid_event_t;

  typedef struct packed {
    logic       emit;
    logic [3:0] mask_next;
    hid_event_t result;
  } xlate_res_t;

  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;

  localparam logic [7:0] USAGE_NONE = 8'h00;
  // Modifier usages 0xE0..0xE7 share the top five bits
  localparam logic [4:0] MOD_USAGE_HI = 5'b11100;

  localparam logic [7:0] BASE_MAP [128] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
    8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
    8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hE0, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hE1, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h55,
    8'hE2, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
    8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
    8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
    8'h45, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h68, 8'h69, 8'h6A, 8'h6B,
    8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h88, 8'h91, 8'h90, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h8A, 8'h00, 8'h8B, 8'h00, 8'h89, 8'h85, 8'h00
  };

  function automatic logic [7:0] ext_lookup(input logic [7:0] code);
    logic [7:0] u;
    case (code)
      8'h1C: u = 8'h58;
      8'h1D: u = 8'hE4;
      8'h35: u = 8'h54;
      8'h37: u = 8'h46;
      8'h38: u = 8'hE6;
      8'h47: u = 8'h4A;
      8'h48: u = 8'h52;
      8'h49: u = 8'h4B;
      8'h4B: u = 8'h50;
      8'h4D: u = 8'h4F;
      8'h4F: u = 8'h4D;
      8'h50: u = 8'h51;
      8'h51: u = 8'h4E;
      8'h52: u = 8'h49;
      8'h53: u = 8'h4C;
      8'h5B: u = 8'hE3;
      8'h5C: u = 8'hE7;
      8'h5D: u = 8'h65;
      default: u = USAGE_NONE;
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/sc2hid_xlate.sv @@
module sc2hid_xlate (
  input  sc2hid_pkg::key_event_t key_event,
  input  logic [3:0]             held,
  output sc2hid_pkg::xlate_res_t res
);

  logic [7:0] usage;
  logic       act_ok;
  logic       down;
  logic       is_mod;
  logic [3:0] mod_bit;

  always_comb begin
    if (key_event.extended) begin
      usage = sc2hid_pkg::ext_lookup(key_event.scan_code);
    end else if (key_event.scan_code[7]) begin
      usage = sc2hid_pkg::USAGE_NONE;
    end else begin
      usage = sc2hid_pkg::BASE_MAP[key_event.scan_code[6:0]];
    end
  end

  assign act_ok  = (key_event.key_action == sc2hid_pkg::ACT_RELEASE) ||
                   (key_event.key_action == sc2hid_pkg::ACT_PRESS);
  assign down    = (key_event.key_action == sc2hid_pkg::ACT_PRESS);
  assign is_mod  = (usage[7:3] == sc2hid_pkg::MOD_USAGE_HI);
  // left and right share one bit
  assign mod_bit = 4'b0001 << usage[1:0];

  always_comb begin
    res.emit                 = act_ok && (usage != sc2hid_pkg::USAGE_NONE) && !is_mod;
    res.result.hid_usage     = usage;
    res.result.pressed       = down;
    res.result.modifier_mask = held;
    res.mask_next            = held;
    if (act_ok && is_mod) begin
      res.mask_next = down ? (held | mod_bit) : (held & ~mod_bit);
    end
  end

endmodule

@@ hw/rtl/scan_code_to_hid_key_events_top.sv @@
// Converts set-1 keyboard scan codes (with E0 flag and press/release action) into
// HID keyboard-page usages. One event is taken per cycle unless key_stall is set.
// The event is captured in the input register when accepted, and its result is
// loaded into the result register once that is free, where hid_valid rises if a
// result was produced. The table lookup and modifier update sit between those two
// registers. Modifier keys produce no result, they only update the mask reported
// with later keys. Unmapped codes and ignored actions are dropped. key_stall rises
// only while a result is held by hid_stall and another event already waits behind it.
module scan_code_to_hid_key_events_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   key_valid,
  output logic                   key_stall,
  input  sc2hid_pkg::key_event_t key_event,
  output logic                   hid_valid,
  input  logic                   hid_stall,
  output sc2hid_pkg::hid_event_t hid_event
);

  logic                   s1_valid;
  sc2hid_pkg::key_event_t s1_event;
  logic [3:0]             held;
  logic                   adv;
  sc2hid_pkg::xlate_res_t res;

  assign adv       = !hid_valid || !hid_stall;
  assign key_stall = s1_valid && !adv;

  sc2hid_xlate u_xlate (
    .key_event (s1_event),
    .held      (held),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      hid_valid <= 1'b0;
      held      <= 4'd0;
    end else begin
      if (key_valid && !key_stall) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        hid_valid <= s1_valid && res.emit;
      end
      if (s1_valid && adv) begin
        held <= res.mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && !key_stall) begin
      s1_event <= key_event;
    end
    if (adv) begin
      hid_event <= res.result;
    end
  end

endmodule

@@ hw/rtl/sc2hid_chk.sv @@
module sc2hid_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   key_valid,
  input logic                   key_stall,
  input sc2hid_pkg::key_event_t key_event,
  input logic                   hid_valid,
  input logic                   hid_stall,
  input sc2hid_pkg::hid_event_t hid_event
);

  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_event))
    else $error("stalled request changed or dropped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hid_valid && hid_stall |=> hid_valid && $stable(hid_event))
    else $error("stalled result changed or dropped");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    hid_valid |-> hid_event.hid_usage != sc2hid_pkg::USAGE_NONE)
    else $error("result with empty usage");

  a_no_mod: assert property (@(posedge clk) disable iff (rst)
    hid_valid |-> hid_event.hid_usage[7:3] != sc2hid_pkg::MOD_USAGE_HI)
    else $error("modifier key produced a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    key_stall |-> hid_valid && hid_stall)
    else $error("input stalled while output is free");

endmodule

bind scan_code_to_hid_key_events_top sc2hid_chk u_sc2hid_chk (
  .clk       (clk),
  .rst       (rst),
  .key_valid (key_valid),
  .key_stall (key_stall),
  .key_event (key_event),
  .hid_valid (hid_valid),
  .hid_stall (hid_stall),
  .hid_event (hid_event)
);

@@ test/hid_event_checker.sv @@
`timescale 1ns / 1ps

module hid_event_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   key_valid,
  input  logic                   key_stall,
  input  sc2hid_pkg::key_event_t key_event,
  input  logic                   hid_valid,
  input  logic                   hid_stall,
  input  sc2hid_pkg::hid_event_t hid_event,
  output int                     fail_count,
  output int                     pending
);
  import sc2hid_pkg::*;

  // Set-1 make codes 0x00..0x7F to keyboard-page usage, zero where unmapped
  localparam logic [7:0] SET1_USAGE [128] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
    8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
    8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hE0, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hE1, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h55,
    8'hE2, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
    8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
    8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
    8'h45, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h68, 8'h69, 8'h6A, 8'h6B,
    8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h88, 8'h91, 8'h90, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h8A, 8'h00, 8'h8B, 8'h00, 8'h89, 8'h85, 8'h00
  };

  function automatic logic [7:0] e0_usage(input logic [7:0] code);
    logic [7:0] u;
    u = 8'h00;
    case (code)
      8'h1C: u = 8'h58;  8'h1D: u = 8'hE4;  8'h35: u = 8'h54;
      8'h37: u = 8'h46;  8'h38: u = 8'hE6;  8'h47: u = 8'h4A;
      8'h48: u = 8'h52;  8'h49: u = 8'h4B;  8'h4B: u = 8'h50;
      8'h4D: u = 8'h4F;  8'h4F: u = 8'h4D;  8'h50: u = 8'h51;
      8'h51: u = 8'h4E;  8'h52: u = 8'h49;  8'h53: u = 8'h4C;
      8'h5B: u = 8'hE3;  8'h5C: u = 8'hE7;  8'h5D: u = 8'h65;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  hid_event_t expected_hid [$];
  logic [3:0] held_mods;

  always @(posedge clk) begin
    hid_event_t want;
    hid_event_t got;
    logic [7:0] usage;
    logic [3:0] mod_bit;
    if (rst) begin
      held_mods = 4'd0;
      expected_hid.delete();
      fail_count = 0;
    end else begin
      if (hid_valid && !hid_stall) begin
        got = hid_event;
        if (expected_hid.size() == 0) begin
          $error("unexpected result: hid_usage %h pressed %b modifier_mask %h",
                 got.hid_usage, got.pressed, got.modifier_mask);
          fail_count++;
        end else begin
          want = expected_hid.pop_front();
          if (got.hid_usage !== want.hid_usage) begin
            $error("hid_usage: expected %h, actual %h", want.hid_usage, got.hid_usage);
            fail_count++;
          end
          if (got.pressed !== want.pressed) begin
            $error("pressed: expected %b, actual %b", want.pressed, got.pressed);
            fail_count++;
          end
          if (got.modifier_mask !== want.modifier_mask) begin
            $error("modifier_mask: expected %h, actual %h",
                   want.modifier_mask, got.modifier_mask);
            fail_count++;
          end
        end
      end
      if (key_valid && !key_stall &&
          (key_event.key_action == ACT_RELEASE || key_event.key_action == ACT_PRESS)) begin
        if (key_event.extended)
          usage = e0_usage(key_event.scan_code);
        else if (key_event.scan_code[7])
          usage = USAGE_NONE;
        else
          usage = SET1_USAGE[key_event.scan_code[6:0]];
        if (usage != USAGE_NONE) begin
          if (usage[7:3] == MOD_USAGE_HI) begin
            // left and right share a bit; either release clears it
            mod_bit = 4'd1 << usage[1:0];
            if (key_event.key_action == ACT_PRESS)
              held_mods = held_mods | mod_bit;
            else
              held_mods = held_mods & ~mod_bit;
          end else begin
            want.hid_usage     = usage;
            want.pressed       = (key_event.key_action == ACT_PRESS);
            want.modifier_mask = held_mods;
            expected_hid.push_back(want);
          end
        end
      end
    end
    pending = expected_hid.size();
  end

endmodule

@@ test/scan_code_to_hid_key_events_top_tb.sv @@
`timescale 1ns / 1ps

module scan_code_to_hid_key_events_top_tb;
  import sc2hid_pkg::*;

  localparam int         RANDOM_KEYS = 1500;
  localparam int         CALM_KEYS   = 300;
  localparam logic [1:0] ACT_IGNORE  = 2'd2;
  localparam logic [1:0] ACT_UNDEF   = 2'd3;
  localparam logic [7:0] E0_CODES [18] = '{
    8'h1C, 8'h1D, 8'h35, 8'h37, 8'h38, 8'h47, 8'h48, 8'h49, 8'h4B,
    8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h5B, 8'h5C, 8'h5D
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       key_valid;
  logic       key_stall;
  key_event_t key_event;
  logic       hid_valid;
  logic       hid_stall = 1'b0;
  hid_event_t hid_event;
  int         fail_count;
  int         pending;
  bit         calm = 1'b0;

  always #5 clk = ~clk;

  scan_code_to_hid_key_events_top dut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_event (key_event),
    .hid_valid (hid_valid),
    .hid_stall (hid_stall),
    .hid_event (hid_event)
  );

  hid_event_checker chk (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_event  (key_event),
    .hid_valid  (hid_valid),
    .hid_stall  (hid_stall),
    .hid_event  (hid_event),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side back-pressure in bursts, off once calm
  always begin
    int n;
    @(negedge clk);
    if (rst || calm || $urandom_range(0, 3) != 0) begin
      hid_stall <= 1'b0;
    end else begin
      n = $urandom_range(1, 13);
      hid_stall <= 1'b1;
      repeat (n) @(negedge clk);
      hid_stall <= 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_key(input logic [7:0] code, input logic ext, input logic [1:0] act);
    key_event_t ev;
    int n;
    ev.scan_code  = code;
    ev.extended   = ext;
    ev.key_action = act;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      key_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    key_valid <= 1'b1;
    key_event <= ev;
    do @(posedge clk); while (key_stall);
    @(negedge clk);
  endtask

  task automatic send_random_key;
    logic [7:0] code;
    logic       ext;
    logic [1:0] act;
    int         r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) != 0)
      act = $urandom_range(0, 1) ? ACT_PRESS : ACT_RELEASE;
    else
      act = $urandom_range(0, 1) ? ACT_IGNORE : ACT_UNDEF;
    if (r < 15) begin
      // noise: any byte, any flag, any action
      code = 8'($urandom_range(0, 255));
      ext  = 1'($urandom_range(0, 1));
      act  = 2'($urandom_range(0, 3));
    end else if (r < 35) begin
      case ($urandom_range(0, 7))
        0: begin code = 8'h1D; ext = 1'b0; end
        1: begin code = 8'h2A; ext = 1'b0; end
        2: begin code = 8'h38; ext = 1'b0; end
        3: begin code = 8'h36; ext = 1'b0; end
        4: begin code = 8'h1D; ext = 1'b1; end
        5: begin code = 8'h38; ext = 1'b1; end
        6: begin code = 8'h5B; ext = 1'b1; end
        default: begin code = 8'h5C; ext = 1'b1; end
      endcase
    end else if (r < 55) begin
      code = E0_CODES[5'($urandom_range(0, 17))];
      ext  = 1'b1;
    end else begin
      code = 8'($urandom_range(1, 127));
      ext  = 1'b0;
    end
    send_key(code, ext, act);
  endtask

  initial begin
    key_valid = 1'b0;
    key_event = '0;
    rst       = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_key(8'h00, 1'b0, ACT_PRESS);     // table entry of zero
    send_key(8'h7F, 1'b0, ACT_PRESS);
    send_key(8'h7E, 1'b0, ACT_PRESS);
    send_key(8'h80, 1'b0, ACT_PRESS);     // code at 0x80 and above
    send_key(8'hFF, 1'b0, ACT_RELEASE);
    send_key(8'h1E, 1'b0, ACT_PRESS);
    send_key(8'h1E, 1'b0, ACT_RELEASE);
    send_key(8'h1E, 1'b0, ACT_IGNORE);
    send_key(8'h1E, 1'b0, ACT_UNDEF);
    send_key(8'h1D, 1'b0, ACT_PRESS);     // left ctrl
    send_key(8'h1D, 1'b1, ACT_PRESS);     // right ctrl, same bit
    send_key(8'h1D, 1'b1, ACT_RELEASE);   // clears while left still down
    send_key(8'h10, 1'b0, ACT_PRESS);
    send_key(8'h2A, 1'b0, ACT_PRESS);
    send_key(8'h38, 1'b1, ACT_PRESS);
    send_key(8'h5B, 1'b1, ACT_PRESS);
    send_key(8'h1D, 1'b0, ACT_PRESS);
    send_key(8'h5D, 1'b1, ACT_PRESS);
    send_key(8'h1C, 1'b1, ACT_RELEASE);
    send_key(8'h00, 1'b1, ACT_PRESS);     // extended, not in map
    send_key(8'hFF, 1'b1, ACT_RELEASE);
    send_key(8'h1D, 1'b0, ACT_IGNORE);    // ignored modifier leaves mask
    send_key(8'h2A, 1'b0, ACT_UNDEF);
    send_key(8'h5C, 1'b1, ACT_RELEASE);
    send_key(8'h36, 1'b0, ACT_RELEASE);
    send_key(8'h01, 1'b0, ACT_PRESS);

    for (int i = 0; i < RANDOM_KEYS; i++) begin
      if (i == RANDOM_KEYS - CALM_KEYS)
        calm = 1'b1;
      send_random_key();
    end
    key_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("scan_code_to_hid_key_events_top: match");
    else
      $display("scan_code_to_hid_key_events_top: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("scan_code_to_hid_key_events_top: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sc2hid_pkg.sv
hw/rtl/sc2hid_xlate.sv
hw/rtl/scan_code_to_hid_key_events_top.sv
hw/rtl/sc2hid_chk.sv
test/hid_event_checker.sv
test/scan_code_to_hid_key_events_top_tb.sv
